FILE: src/ps2md_pkg.sv
// Shared constants for the PS/2 mouse packet decoder.
package ps2md_pkg;

   localparam int BYTE_W      = 8;
   localparam int DELTA_W     = 12;
   localparam int BUTTON_W    = 3;
   localparam int WHEEL_W     = 4;
   localparam int SPEED_W     = 5;
   localparam int CSR_INDEX_W = 1;

   localparam int REQ_DATA_W  = 8;
   localparam int RSP_DATA_W  = 32;

   // speed * reciprocal of five, fixed point
   localparam int DIV5_SHIFT  = 15;
   localparam int DIV5_RECIP  = 6554;
   localparam int MAG_W       = 9;
   localparam int GAIN_W      = 18;
   localparam int PROD_W      = MAG_W + GAIN_W;

   localparam logic [SPEED_W-1:0] SPEED_RESET = 5'd5;
   localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(5 * DIV5_RECIP);
   localparam logic [DELTA_W-1:0] DELTA_LIMIT = 12'd1587;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SPEED      = 1'b0,
      REG_WHEEL_MODE = 1'b1
   } csr_reg_type;

   localparam logic [1:0] POS_FIRST  = 2'd0;
   localparam logic [1:0] POS_THIRD  = 2'd2;
   localparam logic [1:0] POS_FOURTH = 2'd3;

endpackage

FILE: src/ps2_mouse_packet_decoder_top.sv
// PS/2 mouse packet decoder top level: byte framing, scaling and result register.
//
// Takes one mouse byte per request and returns one motion/button/wheel report per
// completed packet without overflow bits that moves, turns the wheel or changes the
// buttons. Packets are three bytes, or four with wheel_mode set; a first byte without
// bit 3 is dropped. A byte is accepted every cycle while rsp_tready is high: it lands
// in an input register, is decoded by one pass of logic (two 9x18 multiplies do the
// speed/5 scaling) and the report is loaded into the result register when the input
// stage advances. With the result stalled, one further byte is held in the input
// stage.
module ps2_mouse_packet_decoder_top (
   input  logic                                   clock,
   input  logic                                   reset,
   // fields: data_byte[7:0]
   input  logic [ps2md_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // fields: delta_x[11:0], delta_y[23:12], button_mask[26:24], wheel_delta[30:27], zero[31]
   output logic [ps2md_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_we,
   input  logic [ps2md_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [ps2md_pkg::SPEED_W-1:0]          csr_wdata
);
   import ps2md_pkg::*;

   logic                  in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]     in_byte_ff;
   logic [1:0]            pos_ff, pos_in;
   logic [BYTE_W-1:0]     packet_ff [3];
   logic [BUTTON_W-1:0]   prev_ff, prev_in;
   logic [GAIN_W-1:0]     gain_ff;
   logic                  wheel_mode_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [DELTA_W-1:0]    dx_ff, dy_ff;
   logic [BUTTON_W-1:0]   buttons_ff;
   logic [WHEEL_W-1:0]    wheel_ff;

   logic                  advance;
   logic                  drop, complete, overflow, emit;
   logic [1:0]            last_pos;
   logic [BYTE_W-1:0]     b0, byte1, byte2;
   logic [MAG_W-1:0]      mag_x, mag_y;
   logic [PROD_W-1:0]     prod_x, prod_y;
   logic [DELTA_W-1:0]    q_x, q_y, sx, sy;
   logic [WHEEL_W-1:0]    wheel;
   logic [BUTTON_W-1:0]   buttons;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      last_pos = wheel_mode_ff ? POS_FOURTH : POS_THIRD;
      drop     = (pos_ff == POS_FIRST) && !in_byte_ff[3];
      complete = !drop && (pos_ff >= last_pos);
      b0       = packet_ff[0];
      byte1    = packet_ff[1];
      byte2    = (pos_ff == POS_THIRD) ? in_byte_ff : packet_ff[2];
      overflow = b0[7] | b0[6];
      buttons  = b0[BUTTON_W-1:0];

      mag_x  = b0[4] ? (MAG_W'(9'h100) - {1'b0, byte1}) : {1'b0, byte1};
      mag_y  = b0[5] ? (MAG_W'(9'h100) - {1'b0, byte2}) : {1'b0, byte2};
      prod_x = PROD_W'(mag_x) * PROD_W'(gain_ff);
      prod_y = PROD_W'(mag_y) * PROD_W'(gain_ff);
      q_x    = prod_x[DIV5_SHIFT +: DELTA_W];
      q_y    = prod_y[DIV5_SHIFT +: DELTA_W];
      sx     = b0[4] ? (DELTA_W'(0) - q_x) : q_x;
      sy     = b0[5] ? q_y : (DELTA_W'(0) - q_y);

      wheel  = (wheel_mode_ff && pos_ff == POS_FOURTH) ? in_byte_ff[WHEEL_W-1:0]
                                                        : WHEEL_W'(0);
      emit   = complete && !overflow &&
               (sx != '0 || sy != '0 || wheel != '0 || buttons != prev_ff);

      pos_in  = pos_ff;
      prev_in = prev_ff;
      if (advance && !drop) begin
         pos_in = complete ? POS_FIRST : pos_ff + 2'd1;
      end
      if (advance && emit) begin
         prev_in = buttons;
      end

      in_valid_in = req_tready ? req_tvalid : in_valid_ff;
      if (advance) begin
         rsp_valid_in = emit;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         pos_ff        <= POS_FIRST;
         prev_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         gain_ff       <= GAIN_RESET;
         wheel_mode_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         pos_ff       <= pos_in;
         prev_ff      <= prev_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_reg_type'(csr_index))
               REG_SPEED:      gain_ff <= GAIN_W'(csr_wdata) * GAIN_W'(DIV5_RECIP);
               REG_WHEEL_MODE: wheel_mode_ff <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata[BYTE_W-1:0];
      end
      if (advance && !drop && pos_ff != POS_FOURTH) begin
         packet_ff[pos_ff] <= in_byte_ff;
      end
      if (advance && emit) begin
         dx_ff      <= sx;
         dy_ff      <= sy;
         buttons_ff <= buttons;
         wheel_ff   <= wheel;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, wheel_ff, buttons_ff, dy_ff, dx_ff};

`ifndef SYNTHESIS
   // a packet in progress always began with a framing byte
   a_framing: assert property (@(posedge clock) disable iff (reset)
      pos_ff != POS_FIRST |-> packet_ff[0][3])
      else $error("packet in progress without framing bit");

   // a stalled input stage keeps its byte
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_byte_ff))
      else $error("input stage lost a byte while stalled");

   // scaled motion magnitude stays within DELTA_LIMIT
   a_dx_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((dx_ff[DELTA_W-1] ? (DELTA_W'(0) - dx_ff) : dx_ff) <= DELTA_LIMIT)
                    && ((dy_ff[DELTA_W-1] ? (DELTA_W'(0) - dy_ff) : dy_ff) <= DELTA_LIMIT))
      else $error("scaled motion out of range");

   // a new request only reaches the result register through the input stage
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff ##1 rsp_valid_ff |-> $past(in_valid_ff))
      else $error("result appeared without a staged request");
`endif

endmodule
